// ===== sv/gs5_pkg.sv =====
// Shared types, constants and helpers for the five-point Gauss-Seidel sweep.
// No dependencies; imported by gs5_if, gauss_seidel_5pt_sweep and gs5_tap.
`timescale 1ns / 1ps
`default_nettype none

package gs5_pkg;

   localparam int MAX_INTERIOR_DEF = 256;
   localparam int VALUE_W          = 32;
   localparam int COORD_W          = 9;
   localparam logic [COORD_W-1:0] WIDTH_RESET = 9'd64;

   // A Q16.16 value x is held as x + 2^31 = 5*q + r, r in 0..4
   localparam int Q_W = 30;
   localparam int R_W = 3;

   typedef struct packed {
      logic [Q_W-1:0] q;
      logic [R_W-1:0] r;
   } dq_type;

   localparam logic [31:0] RECIP5   = 32'hCCCC_CCCD;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

   // split a signed value into quotient and remainder by five (offset binary)
   function automatic dq_type fifth_split(input logic signed [VALUE_W-1:0] x);
      logic [31:0] n;
      logic [63:0] p;
      logic [31:0] rem;
      dq_type      d;
      n   = {~x[31], x[30:0]};
      p   = {32'b0, n} * {32'b0, RECIP5};
      rem = n - {p[63:34], 2'b00} - {2'b00, p[63:34]};
      d.q = p[63:34];
      d.r = rem[R_W-1:0];
      return d;
   endfunction

   // floor(v / 5) for the small residue sum, v in 0..22
   function automatic logic [2:0] residue_fifth(input logic [4:0] v);
      logic [2:0] f;
      if (v >= 5'd20)      f = 3'd4;
      else if (v >= 5'd15) f = 3'd3;
      else if (v >= 5'd10) f = 3'd2;
      else if (v >= 5'd5)  f = 3'd1;
      else                 f = 3'd0;
      return f;
   endfunction

endpackage

`default_nettype wire

// ===== sv/gs5_if.sv =====
// Channel interfaces of the sweep block: request, response and register write.
// Depends on gs5_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gs5_req_if import gs5_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  cell_value;
   logic                       frame_start;

   modport source (output valid, output cell_value, output frame_start, input ready);
   modport sink   (input valid, input cell_value, input frame_start, output ready);
endinterface

interface gs5_rsp_if import gs5_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  new_value;
   logic [COORD_W-1:0]         cell_row;
   logic [COORD_W-1:0]         cell_col;
   logic                       sweep_last;

   modport source (output valid, output new_value, output cell_row, output cell_col,
                   output sweep_last, input ready);
   modport sink   (input valid, input new_value, input cell_row, input cell_col,
                   input sweep_last, output ready);
endinterface

interface gs5_csr_if import gs5_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COORD_W-1:0]  interior_width;

   modport source (output valid, output interior_width, input ready);
   modport sink   (input valid, input interior_width, output ready);
endinterface

`default_nettype wire

// ===== sv/gauss_seidel_5pt_sweep.sv =====
// Channel    Dir  Handshake      Payload
// req_ch     in   valid/ready    cell_value, frame_start
// rsp_ch     out  valid/ready    new_value, cell_row, cell_col, sweep_last
// csr_ch     in   valid/ready    interior_width (ready always high)
//
// One request per cycle unless responses stall; a registered response follows the
// request holding the lower neighbour of its cell, i.e. one grid row late.
// The per-cycle figure is set by the left-neighbour loop: split by five of the
// previous result (one 32x32 constant multiply) plus a five-way add.
// Synchronous reset clears counters, pipeline valids and the width register
// (to 64); the row stores need no clearing.
// A stalled response holds the update stage while it holds an interior cell; requests then wait once it is full.
//
// Top level of the sweep; depends on gs5_pkg, gs5_if, gs5_ram and gs5_tap.
`timescale 1ns / 1ps
`default_nettype none

module gauss_seidel_5pt_sweep import gs5_pkg::*; #(
   parameter int MAX_INTERIOR = MAX_INTERIOR_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   gs5_req_if.sink   req_ch,
   gs5_rsp_if.source rsp_ch,
   gs5_csr_if.sink   csr_ch
);

   localparam int DEPTH = MAX_INTERIOR + 2;
   localparam int CW    = $clog2(DEPTH);
   localparam int DQW   = $bits(dq_type);

   typedef struct packed {
      logic          comp;       // interior cell updated by this request
      logic          top_row;    // top halo row: seeds the updated store
      logic          row_start;  // left halo: seeds the left neighbour
      logic          last;
      logic [CW-1:0] gr;
      logic [CW-1:0] gc;
   } a_ctl_type;

   // configuration and position
   logic [COORD_W-1:0] width_ff;
   logic [CW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [CW-1:0]      w_eff, last_pos, gr_c, gc_c;
   logic               in_row_c, accept;
   a_ctl_type          ctl_c;

   // update stage
   logic                      a_valid_ff;
   a_ctl_type                 a_ctl_ff;
   logic signed [VALUE_W-1:0] a_cell_ff, a_seed_ff, col0_ff;
   logic signed [VALUE_W-1:0] left_ff, left_in;
   logic                      a_go, out_free;

   // row stores and window
   dq_type        dq_cell_c, a_dq_cell, old_here, old_rd, upd_rd, dq_left;
   logic [CW-1:0] old_raddr;
   logic          wb_en_ff;
   logic [CW-1:0] wb_addr_ff;
   logic signed [VALUE_W-1:0] wb_raw_ff;
   dq_type        wb_dq;

   logic [31:0]               qsum;
   logic [4:0]                rsum;
   logic signed [VALUE_W-1:0] nv_c;

   // response register
   logic                      o_valid_ff, o_valid_in;
   logic signed [VALUE_W-1:0] o_value_ff;
   logic [COORD_W-1:0]        o_row_ff, o_col_ff;
   logic                      o_last_ff;

   // ---------------- position of the incoming request ----------------
   always_comb begin
      if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (32'(width_ff) > 32'(MAX_INTERIOR)) begin
         w_eff = CW'(MAX_INTERIOR);
      end else begin
         w_eff = CW'(width_ff);
      end
      last_pos = w_eff + CW'(1);
      gr_c     = req_ch.frame_start ? '0 : row_ff;
      gc_c     = req_ch.frame_start ? '0 : col_ff;
      in_row_c = (gc_c <= last_pos);

      ctl_c.comp      = in_row_c && (gr_c >= CW'(2)) && (gr_c <= last_pos)
                        && (gc_c >= CW'(1)) && (gc_c <= w_eff);
      ctl_c.top_row   = in_row_c && (gr_c == '0);
      ctl_c.row_start = (gc_c == '0);
      ctl_c.last      = (gr_c == last_pos) && (gc_c == w_eff);
      ctl_c.gr        = gr_c;
      ctl_c.gc        = gc_c;

      if (gc_c >= last_pos) begin
         col_in = '0;
         row_in = (gr_c >= last_pos) ? '0 : gr_c + CW'(1);
      end else begin
         col_in = gc_c + CW'(1);
         row_in = gr_c;
      end

      old_raddr = (gc_c < last_pos) ? gc_c + CW'(1) : '0;
      dq_cell_c = fifth_split(req_ch.cell_value);
   end

   assign accept        = req_ch.valid && req_ch.ready;
   assign out_free      = !o_valid_ff || rsp_ch.ready;
   assign a_go          = a_valid_ff && (!a_ctl_ff.comp || out_free);
   assign req_ch.ready  = !a_valid_ff || a_go;
   assign csr_ch.ready  = 1'b1;

   // ---------------- row stores ----------------
   // old row store holds the last row as it arrived, read one column ahead
   gs5_ram #(.WIDTH(DQW), .DEPTH(DEPTH)) u_old_ram (
      .clock (clock),
      .we    (accept && in_row_c),
      .waddr (gc_c),
      .wdata (dq_cell_c),
      .re    (accept),
      .raddr (old_raddr),
      .rdata (old_rd)
   );

   // updated row store, written from the write-back register in the cycle after the update stage
   assign wb_dq = fifth_split(wb_raw_ff);

   gs5_ram #(.WIDTH(DQW), .DEPTH(DEPTH)) u_upd_ram (
      .clock (clock),
      .we    (wb_en_ff),
      .waddr (wb_addr_ff),
      .wdata (wb_dq),
      .re    (accept),
      .raddr (gc_c),
      .rdata (upd_rd)
   );

   // window: old[gc] is what the previous request fetched as old[gc+1]
   gs5_tap u_win_tap (
      .clock (clock),
      .load  (accept),
      .d_in  (old_rd),
      .d_out (old_here)
   );

   gs5_tap u_cell_tap (
      .clock (clock),
      .load  (accept),
      .d_in  (dq_cell_c),
      .d_out (a_dq_cell)
   );

   // ---------------- update stage ----------------
   // mean of five rounded: sum of quotients plus floor((sum of residues + 2) / 5),
   // offset of 2^31 removed by flipping the sign bit
   always_comb begin
      dq_left = fifth_split(left_ff);
      qsum = 32'(a_dq_cell.q) + 32'(old_here.q) + 32'(old_rd.q)
           + 32'(upd_rd.q) + 32'(dq_left.q);
      rsum = 5'(a_dq_cell.r) + 5'(old_here.r) + 5'(old_rd.r)
           + 5'(upd_rd.r) + 5'(dq_left.r) + 5'd2;
      nv_c = (qsum + 32'(residue_fifth(rsum))) ^ SIGN_BIT;

      left_in = left_ff;
      if (a_go && a_ctl_ff.row_start) begin
         left_in = a_seed_ff;
      end else if (a_go && a_ctl_ff.comp) begin
         left_in = nv_c;
      end

      o_valid_in = (o_valid_ff && !rsp_ch.ready) || (a_go && a_ctl_ff.comp);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         row_ff     <= '0;
         col_ff     <= '0;
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         wb_en_ff   <= 1'b0;
         left_ff    <= '0;
      end else begin
         if (csr_ch.valid) begin
            width_ff <= csr_ch.interior_width;
         end
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (a_go) begin
            a_valid_ff <= 1'b0;
         end
         o_valid_ff <= o_valid_in;
         wb_en_ff   <= a_go && (a_ctl_ff.comp || a_ctl_ff.top_row);
         left_ff    <= left_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         a_ctl_ff  <= ctl_c;
         a_cell_ff <= req_ch.cell_value;
         a_seed_ff <= col0_ff;
         if (ctl_c.row_start) begin
            col0_ff <= req_ch.cell_value;
         end
      end
      if (a_go) begin
         wb_addr_ff <= a_ctl_ff.gc;
         wb_raw_ff  <= a_ctl_ff.comp ? nv_c : a_cell_ff;
      end
      if (a_go && a_ctl_ff.comp) begin
         o_value_ff <= nv_c;
         o_row_ff   <= COORD_W'(a_ctl_ff.gr - CW'(1));
         o_col_ff   <= COORD_W'(a_ctl_ff.gc);
         o_last_ff  <= a_ctl_ff.last;
      end
   end

   assign rsp_ch.valid      = o_valid_ff;
   assign rsp_ch.new_value  = o_value_ff;
   assign rsp_ch.cell_row   = o_row_ff;
   assign rsp_ch.cell_col   = o_col_ff;
   assign rsp_ch.sweep_last = o_last_ff;

endmodule

`default_nettype wire

// ===== sv/gs5_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gs5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 258
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/gs5_tap.sv =====
// Stencil window cell: holds one split value and hands it on when loaded.
// Depends on gs5_pkg for dq_type.
`timescale 1ns / 1ps
`default_nettype none

module gs5_tap import gs5_pkg::*; (
   input  wire logic   clock,
   input  wire logic   load,
   input  wire dq_type d_in,
   output dq_type      d_out
);

   dq_type tap_ff;
   dq_type tap_in;

   always_comb begin
      tap_in = load ? d_in : tap_ff;
   end

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
   end

   assign d_out = tap_ff;

endmodule

`default_nettype wire

// ===== sv/gs5_check.sv =====
// Port-level checks of the sweep block's response channel, bound to the top level.
// Depends on gauss_seidel_5pt_sweep and its channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module gs5_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_new_value,
   input wire logic [8:0]  rsp_cell_row,
   input wire logic [8:0]  rsp_cell_col,
   input wire logic        rsp_sweep_last
);

   // no response survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_value)
         && $stable(rsp_cell_row) && $stable(rsp_cell_col) && $stable(rsp_sweep_last))
      else $error("stalled response changed");

   // only interior cells are ever reported
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cell_row != 9'd0 && rsp_cell_col != 9'd0)
      else $error("halo cell reported");

   // the closing cell sits on the diagonal corner
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sweep_last |-> rsp_cell_row == rsp_cell_col)
      else $error("sweep end off the corner cell");

endmodule

bind gauss_seidel_5pt_sweep gs5_check u_gs5_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_new_value  (rsp_ch.new_value),
   .rsp_cell_row   (rsp_ch.cell_row),
   .rsp_cell_col   (rsp_ch.cell_col),
   .rsp_sweep_last (rsp_ch.sweep_last)
);

`default_nettype wire
